@@ hdl/rcfp_pkg.sv @@
// Shared types and constants of the radio-control channel frame parser.
package rcfp_pkg;

    // Table geometry.
    localparam int CHANNEL_LIMIT = 16;
    localparam int TABLE_DEPTH   = 16;
    localparam int EFF_LIMIT     = (CHANNEL_LIMIT < TABLE_DEPTH) ? CHANNEL_LIMIT : TABLE_DEPTH;
    localparam int INDEX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W       = 5;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int PULSE_W = 11;

    // Pulse conversion constants.
    localparam logic [PULSE_W-1:0] PULSE_BASE  = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 11'd1500;

    // Reset value of the sync register.
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd168;

    // Clamp value for the received channel count, and the last table index.
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(EFF_LIMIT);
    localparam logic [INDEX_W-1:0] LAST_IDX  = INDEX_W'(EFF_LIMIT - 1);

    // Write into the raw byte memory.
    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } t_raw_wr;

    // Request to update and emit the table after a good check byte.
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
    } t_sweep_cmd;

endpackage

@@ hdl/rc_channel_frame_parser.sv @@
// Top level of the radio-control channel frame parser.
//
// Input stream: one received serial byte per word on the slave side
// (tdata[7:0] = rx_byte). Bytes before a sync byte are dropped; a frame is
// sync, status, channel count, one byte per channel and an XOR check byte.
// Output stream: after a good check the whole 16-entry pulse table is sent,
// one channel per word, tdata[3:0] = channel_index, tdata[14:4] = pulse_us,
// tlast on channel 15. A bad check drops the frame with no output.
// Configuration: i_cfg_we writes i_cfg_wdata into the sync byte register.
// Throughput: a frame byte is taken every cycle while parsing. After the
// check byte, the sweep through the table memories emits one word per cycle
// (16 words) while the receiver does not stall; the first word passes the
// sweep's read stage and then the output register. The input is held off
// (tready low) until the read-modify-write sweep over the table memory has
// written back its last entry. A stalled receiver holds the output register
// and stops the sweep; nothing is lost. Reset clears the parser to sync
// search, sets the sync byte to 168 and makes every table entry read as
// 1500 us; no clearing pass is needed.
module rc_channel_frame_parser
    import rcfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [3:0] channel_index, [14:4] pulse_us, [15] zero
    output logic        o_m_axis_tlast
);

    t_raw_wr            raw_wr;
    t_sweep_cmd         sweep;
    logic               busy;
    logic [INDEX_W-1:0] out_index;
    logic [PULSE_W-1:0] out_pulse;

    // Byte parser.
    rcfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_busy      (busy),
        .o_raw_wr    (raw_wr),
        .o_sweep     (sweep)
    );

    // Table memories and emit sweep.
    rcfp_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_raw_wr (raw_wr),
        .i_sweep  (sweep),
        .o_busy   (busy),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_index  (out_index),
        .o_pulse  (out_pulse),
        .o_last   (o_m_axis_tlast)
    );

    // Pack the output word.
    assign o_m_axis_tdata = {1'b0, out_pulse, out_index};

endmodule

@@ hdl/rcfp_parser.sv @@
// Byte-level frame parser: sync search, header, channel bytes and XOR check.
module rcfp_parser
    import rcfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_busy,
    output t_raw_wr           o_raw_wr,
    output t_sweep_cmd        o_sweep
);

    // Parse phase codes.
    localparam logic [2:0] PH_SYNC     = 3'd0;
    localparam logic [2:0] PH_STATUS   = 3'd1;
    localparam logic [2:0] PH_COUNT    = 3'd2;
    localparam logic [2:0] PH_CHANNELS = 3'd3;
    localparam logic [2:0] PH_CHECK    = 3'd4;

    logic [BYTE_W-1:0]  r_sync;
    logic [2:0]         r_phase,  n_phase;
    logic [COUNT_W-1:0] r_pos,    n_pos;
    logic [COUNT_W-1:0] r_nchan,  n_nchan;
    logic [BYTE_W-1:0]  r_check,  n_check;
    logic               accept;
    logic [COUNT_W-1:0] pos_inc;
    logic [COUNT_W-1:0] clamped;

    // Bytes are held off while the table sweep is running.
    assign o_ready = ~i_busy;
    assign accept  = i_valid & ~i_busy;
    assign pos_inc = r_pos + COUNT_W'(1);
    assign clamped = (i_byte > BYTE_W'(COUNT_MAX)) ? COUNT_MAX : i_byte[COUNT_W-1:0];

    // Next-state logic for the parse sequencer.
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_nchan  = r_nchan;
        n_check  = r_check;
        o_raw_wr = '0;
        o_sweep  = '0;
        o_sweep.count = r_nchan;
        if (accept) begin
            case (r_phase)
                PH_SYNC: begin
                    if (i_byte == r_sync) begin
                        n_check = i_byte;
                        n_pos   = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    n_check = r_check ^ i_byte;
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    n_check = r_check ^ i_byte;
                    n_nchan = clamped;
                    n_pos   = '0;
                    n_phase = (clamped == '0) ? PH_CHECK : PH_CHANNELS;
                end
                PH_CHANNELS: begin
                    n_check       = r_check ^ i_byte;
                    o_raw_wr.en   = 1'b1;
                    o_raw_wr.addr = r_pos[INDEX_W-1:0];
                    o_raw_wr.data = i_byte;
                    n_pos         = pos_inc;
                    if (pos_inc >= r_nchan) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase       = PH_SYNC;
                    n_pos         = '0;
                    o_sweep.start = (i_byte == r_check);
                end
                default: begin
                    n_phase = PH_SYNC;
                    n_pos   = '0;
                end
            endcase
        end
    end

    // Parser state and sync register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= SYNC_RESET;
            r_phase <= PH_SYNC;
            r_pos   <= '0;
            r_nchan <= '0;
            r_check <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sync <= i_cfg_wdata;
            end
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_nchan <= n_nchan;
            r_check <= n_check;
        end
    end

endmodule

@@ hdl/rcfp_table.sv @@
// Raw byte memory, pulse table memory and the update/emit sweep.
module rcfp_table
    import rcfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_raw_wr            i_raw_wr,
    input  t_sweep_cmd         i_sweep,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [INDEX_W-1:0] o_index,
    output logic [PULSE_W-1:0] o_pulse,
    output logic               o_last
);

    logic [BYTE_W-1:0]  mem_raw [TABLE_DEPTH];
    logic [PULSE_W-1:0] mem_pul [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_pvld;

    logic               r_active;
    logic [INDEX_W-1:0] r_issue_idx;
    logic [COUNT_W-1:0] r_count;
    logic               r_s1_vld;
    logic [INDEX_W-1:0] r_s1_idx;
    logic [BYTE_W-1:0]  r_raw_q;
    logic [PULSE_W-1:0] r_pul_q;
    logic               r_pvld_q;
    logic               r_o_vld;
    logic [INDEX_W-1:0] r_o_idx;
    logic [PULSE_W-1:0] r_o_pulse;
    logic               r_o_last;

    logic               out_free;
    logic               s1_go;
    logic               issue;
    logic [PULSE_W-1:0] new_pulse;

    // While the sweep is active, a read is issued when the read stage is empty or moves on this cycle.
    assign out_free = ~r_o_vld | i_ready;
    assign s1_go    = r_s1_vld & out_free;
    assign issue    = r_active & (~r_s1_vld | s1_go);
    assign o_busy   = r_active | r_s1_vld;

    // Received channels take the new width; the rest keep the stored one, or the reset width if never written.
    always_comb begin
        if ({1'b0, r_s1_idx} < r_count) begin
            new_pulse = PULSE_BASE + {1'b0, r_raw_q, 2'b00};
        end else if (r_pvld_q) begin
            new_pulse = r_pul_q;
        end else begin
            new_pulse = PULSE_RESET;
        end
    end

    // Raw byte memory: written by the parser, read by the sweep.
    always_ff @(posedge i_clk) begin
        if (i_raw_wr.en) begin
            mem_raw[i_raw_wr.addr] <= i_raw_wr.data;
        end
        if (issue) begin
            r_raw_q <= mem_raw[r_issue_idx];
        end
    end

    // Pulse table memory: read one entry ahead, written back as it is emitted.
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            mem_pul[r_s1_idx] <= new_pulse;
        end
        if (issue) begin
            r_pul_q  <= mem_pul[r_issue_idx];
            r_pvld_q <= r_pvld[r_issue_idx];
        end
    end

    // Entry valid bits; an entry never written reads as the reset width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= '0;
        end else if (s1_go) begin
            r_pvld[r_s1_idx] <= 1'b1;
        end
    end

    // Sweep sequencer and read stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_issue_idx <= '0;
            r_count     <= '0;
            r_s1_vld    <= 1'b0;
            r_s1_idx    <= '0;
        end else begin
            if (i_sweep.start) begin
                r_active    <= 1'b1;
                r_issue_idx <= '0;
                r_count     <= i_sweep.count;
            end else if (issue) begin
                r_issue_idx <= r_issue_idx + INDEX_W'(1);
                if (r_issue_idx == LAST_IDX) begin
                    r_active <= 1'b0;
                end
            end
            if (issue) begin
                r_s1_vld <= 1'b1;
                r_s1_idx <= r_issue_idx;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    // Output register; holds its word while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_go) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_o_idx   <= r_s1_idx;
            r_o_pulse <= new_pulse;
            r_o_last  <= (r_s1_idx == LAST_IDX);
        end
    end

    assign o_valid = r_o_vld;
    assign o_index = r_o_idx;
    assign o_pulse = r_o_pulse;
    assign o_last  = r_o_last;

endmodule

@@ hdl/rcfp_checker.sv @@
// Port-level assertions for the frame parser, bound to the top level.
module rcfp_checker
    import rcfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic [INDEX_W-1:0] r_exp_idx;

    // Channel index expected on the next output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_exp_idx <= o_m_axis_tlast ? '0 : r_exp_idx + INDEX_W'(1);
        end
    end

    // Words of a table come in order, starting at channel zero.
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[INDEX_W-1:0] == r_exp_idx)
        else $error("output channel index out of sequence");

    // The last flag marks exactly the final table entry.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[INDEX_W-1:0] == LAST_IDX)))
        else $error("tlast does not match the final channel");

    // Pulse widths stay within the converted range.
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:4] >= PULSE_BASE &&
                             o_m_axis_tdata[14:4] <= 11'd2020))
        else $error("pulse width out of range");

    // No new byte is taken while a table is only partly sent.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("input accepted during a table sweep");

    // A stalled output word holds.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled output word changed");

endmodule

bind rc_channel_frame_parser rcfp_checker u_rcfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ bench/tb_rc_channel_frame_parser.sv @@
// Self-checking bench for the radio-control frame parser: frame stimulus, table prediction.
`timescale 1ns / 100ps

module tb_rc_channel_frame_parser;
    import rcfp_pkg::*;

    localparam int PULSE_STEP   = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 320;
    localparam int PHASES       = 5;

    // Parser position within a frame.
    typedef enum logic [2:0] {P_HUNT, P_STATUS, P_COUNT, P_CHANNELS, P_CHECK} parse_e;

    // One emitted table entry.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [PULSE_W-1:0] pulse;
        logic               last;
    } channel_word_t;

    // Tracks the frame parser and the pulse table, and holds the words still owed.
    class pulse_table_scoreboard;
        logic [BYTE_W-1:0]  sync_byte;
        parse_e             phase;
        logic [COUNT_W-1:0] position;
        logic [COUNT_W-1:0] channels;
        logic [BYTE_W-1:0]  xor_sum;
        logic [BYTE_W-1:0]  raw_bytes [TABLE_DEPTH];
        logic [PULSE_W-1:0] pulses [TABLE_DEPTH];
        channel_word_t      expected_words [$];
        int                 errors;

        function new();
            sync_byte = SYNC_RESET;
            phase     = P_HUNT;
            position  = '0;
            channels  = '0;
            xor_sum   = '0;
            errors    = 0;
            foreach (pulses[k]) pulses[k] = PULSE_RESET;
            foreach (raw_bytes[k]) raw_bytes[k] = '0;
        endfunction

        function void set_sync(logic [BYTE_W-1:0] value);
            sync_byte = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Advance by one accepted byte; a matching check byte queues the whole table.
        function void note_byte(logic [BYTE_W-1:0] b);
            channel_word_t w;
            case (phase)
                P_HUNT: begin
                    if (b == sync_byte) begin
                        xor_sum  = b;
                        position = '0;
                        phase    = P_STATUS;
                    end
                end
                P_STATUS: begin
                    xor_sum ^= b;
                    phase = P_COUNT;
                end
                P_COUNT: begin
                    // The raw count enters the check even when it gets clamped.
                    xor_sum ^= b;
                    channels = (b > EFF_LIMIT) ? COUNT_MAX : b[COUNT_W-1:0];
                    position = '0;
                    phase    = (channels == 0) ? P_CHECK : P_CHANNELS;
                end
                P_CHANNELS: begin
                    xor_sum ^= b;
                    raw_bytes[position[INDEX_W-1:0]] = b;
                    position = position + 1'b1;
                    if (position >= channels) phase = P_CHECK;
                end
                default: begin
                    phase    = P_HUNT;
                    position = '0;
                    if (b == xor_sum) begin
                        for (int k = 0; k < TABLE_DEPTH; k++) begin
                            if (k < channels)
                                pulses[k] = PULSE_W'(PULSE_BASE + PULSE_STEP * raw_bytes[k]);
                        end
                        for (int k = 0; k < EFF_LIMIT; k++) begin
                            w.index = INDEX_W'(k);
                            w.pulse = pulses[k];
                            w.last  = (k == EFF_LIMIT - 1);
                            expected_words.push_back(w);
                        end
                    end
                end
            endcase
        endfunction

        // Compare one received word with the oldest one owed.
        function void check_word(channel_word_t got);
            channel_word_t want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: channel_index %0d pulse_us %0d last %0d",
                       got.index, got.pulse, got.last);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.index !== want.index) begin
                $error("channel_index: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.pulse !== want.pulse) begin
                $error("pulse_us: expected %0d, got %0d", want.pulse, got.pulse);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [7:0]  i_cfg_wdata     = 8'h00;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;            // [3:0] channel_index, [14:4] pulse_us, [15] zero
    logic        o_m_axis_tlast;

    pulse_table_scoreboard sb;
    logic [7:0] sync_now   = SYNC_RESET;
    bit         quiet      = 1'b0;
    int         frame_bytes = 0;
    int         stall_left  = 0;
    int         cycle_count = 0;

    rc_channel_frame_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Receiver stalls now and then in bursts of random length, outside the quiet phase.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Check every word taken on the output side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word({o_m_axis_tdata[3:0], o_m_axis_tdata[14:4], o_m_axis_tlast});
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one byte, with an occasional gap before it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input bit counted);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_byte(b);
        if (counted) frame_bytes++;
    endtask

    // Send a whole frame. With extremes set, the first channels carry 0x00, 0xff and the sync value.
    task automatic send_frame(input logic [7:0] status, input logic [7:0] count_b,
                              input bit good, input bit extremes);
        logic [7:0] chk;
        logic [7:0] ch;
        int         n;
        n   = (count_b > EFF_LIMIT) ? EFF_LIMIT : count_b;
        chk = sync_now ^ status ^ count_b;
        send_byte(sync_now, 1'b1);
        send_byte(status, 1'b1);
        send_byte(count_b, 1'b1);
        for (int k = 0; k < n; k++) begin
            ch = 8'($urandom);
            if (extremes)
                ch = (k == 0) ? 8'h00 : (k == 1) ? 8'hff : (k == 2) ? sync_now : ch;
            chk ^= ch;
            send_byte(ch, 1'b1);
        end
        send_byte(good ? chk : chk ^ 8'($urandom_range(1, 255)), 1'b1);
    endtask

    // Mostly well-formed frames, some with line noise ahead, bad checks or cut short.
    task automatic random_frame();
        logic [7:0] b;
        logic [7:0] cnt;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom);
                if (b == sync_now) b ^= 8'h01;
                send_byte(b, 1'b0);
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            // The frame stops partway; the next frame's bytes land in its place.
            cnt = 8'($urandom_range(1, 16));
            send_byte(sync_now, 1'b1);
            send_byte(8'($urandom), 1'b1);
            send_byte(cnt, 1'b1);
            repeat ($urandom_range(0, cnt - 1)) send_byte(8'($urandom), 1'b1);
        end else begin
            cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(17, 255))
                                              : 8'($urandom_range(0, 16));
            send_frame(8'($urandom), cnt, $urandom_range(0, 6) != 0, 1'b0);
        end
    endtask

    // Let the block drain, then write the sync register.
    task automatic write_sync(input logic [7:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_sync(value);
        sync_now = value;
    endtask

    initial begin
        int         ph;
        int         target;
        logic [7:0] v;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: noise before sync, an empty frame, a bad check, a clamped count.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_frame(8'h00, 8'h00, 1'b1, 1'b0);
        send_frame(8'hff, 8'h01, 1'b0, 1'b1);
        send_frame(8'h5a, 8'hff, 1'b1, 1'b1);

        // Random frames under several sync values; the last phase runs without gaps.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: v = 8'h00;
                1: v = 8'hff;
                PHASES - 1: v = SYNC_RESET;
                default: v = 8'($urandom);
            endcase
            write_sync(v);
            quiet  = (ph == PHASES - 1);
            target = frame_bytes + RANDOM_BYTES / PHASES;
            while (frame_bytes < target) random_frame();
        end

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
